### design/rcbf_pkg.sv
// ----------------------------------------------------------------------------
// rcbf_pkg
// Shared types and constants of the PCM rate converter buffer filler.
// ----------------------------------------------------------------------------
package rcbf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SRC_RATE_W = 18;
	localparam int OUT_RATE_W = 16;
	localparam int SLOT_W     = 10;
	localparam int BUFNUM_W   = 4;
	localparam int SAMPLES_W  = 12;
	localparam int SKIP_W     = 5;

	// frames one source byte may give at most, and its counter width
	localparam int MAX_FRAMES = 64;
	localparam int FRAME_N_W  = 6;

	localparam logic [SKIP_W-1:0] SKIP_MAX = 5'd31;
	localparam logic [7:0]        SILENCE  = 8'h80;

	localparam logic [SRC_RATE_W-1:0] SRC_RATE_MIN   = 18'd750;
	localparam logic [SRC_RATE_W-1:0] SRC_RATE_MAX   = 18'd192000;
	localparam logic [SRC_RATE_W-1:0] SRC_RATE_RESET = 18'd48000;
	localparam logic [OUT_RATE_W-1:0] OUT_RATE_MIN   = 16'd8000;
	localparam logic [OUT_RATE_W-1:0] OUT_RATE_MAX   = 16'd48000;
	localparam logic [OUT_RATE_W-1:0] OUT_RATE_RESET = 16'd48000;

	// register indexes of the write port
	localparam logic REG_SOURCE_RATE = 1'b0;
	localparam logic REG_OUTPUT_RATE = 1'b1;

	// input queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} q_item_t;

	typedef struct packed {
		logic [SRC_RATE_W-1:0] src_hz;
		logic [OUT_RATE_W-1:0] out_hz;
	} rates_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       frame_valid;
		logic [BUFNUM_W-1:0]        buffer_number;
		logic [SLOT_W-1:0]          frame_slot;
		logic                       buffer_end;
		logic [SAMPLES_W-1:0]       buffer_samples;
		logic                       last_of_item;
	} result_t;

endpackage

### design/rcbf_front.sv
// ----------------------------------------------------------------------------
// rcbf_front
// Accepts source bytes, converts them to signed samples and queues them.
// ----------------------------------------------------------------------------
module rcbf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] source_byte
	input  logic             s_tlast,
	output logic             head_valid,
	output rcbf_pkg::q_item_t head,
	input  logic             pop
);

	rcbf_pkg::q_item_t mem_q [rcbf_pkg::QDEPTH];
	logic [rcbf_pkg::QPTR_W-1:0] wr_q;
	logic [rcbf_pkg::QPTR_W-1:0] rd_q;
	logic [rcbf_pkg::QCNT_W-1:0] count_q;
	logic push;
	rcbf_pkg::q_item_t item;

	assign s_tready   = count_q != rcbf_pkg::QCNT_W'(rcbf_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign push       = s_tvalid && s_tready;
	assign head       = mem_q[rd_q];

	// unsigned byte to signed 16-bit: flip the sign bit, scale by 256
	always_comb begin
		item.sample = {s_tdata ^ rcbf_pkg::SILENCE, 8'h00};
		item.last   = s_tlast;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + rcbf_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + rcbf_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rcbf_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rcbf_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

### design/rcbf_engine.sv
// ----------------------------------------------------------------------------
// rcbf_engine
// Phase accumulator sequencer: emits frames, tracks skips and ring buffers.
// ----------------------------------------------------------------------------
module rcbf_engine #(
	parameter int BUFFER_COUNT      = 16,
	parameter int FRAMES_PER_BUFFER = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rcbf_pkg::rates_t  rates,
	input  logic              head_valid,
	input  rcbf_pkg::q_item_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output rcbf_pkg::result_t out_word
);

	localparam int BUF_W = $clog2(BUFFER_COUNT);
	localparam int FIB_W = $clog2(FRAMES_PER_BUFFER + 1);
	localparam int N_W   = rcbf_pkg::FRAME_N_W;
	localparam int PH_W  = rcbf_pkg::SRC_RATE_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FRAME = 2'd1;
	localparam logic [1:0] ST_SUB   = 2'd2;

	logic [1:0]                      state_q, state_d;
	logic [PH_W-1:0]                 phase_q, phase_d;
	logic [rcbf_pkg::SKIP_W-1:0]     skip_q, skip_d;
	logic [rcbf_pkg::SKIP_W-1:0]     extra_q, extra_d;
	logic [BUF_W-1:0]                buf_q, buf_d;
	logic [FIB_W-1:0]                fib_q, fib_d;
	logic [N_W-1:0]                  n_q, n_d;
	logic [rcbf_pkg::SAMPLE_W-1:0]   sample_q, sample_d;
	logic                            last_q, last_d;
	rcbf_pkg::result_t               out_q;
	logic                            out_valid_q;

	logic                            slot_free;
	logic                            load_out;
	rcbf_pkg::result_t               res;
	logic [PH_W:0]                   sum_w;
	logic [PH_W:0]                   out_rate_w;
	logic                            ge;
	logic                            done;
	logic                            closes;
	logic [FIB_W-1:0]                frames_new;
	logic [FIB_W:0]                  twice_new;
	logic [FIB_W:0]                  twice_cur;
	logic [BUF_W-1:0]                next_buf;

	assign slot_free  = !out_valid_q || out_ready;
	assign out_rate_w = (PH_W + 1)'(rates.out_hz);
	assign sum_w      = (PH_W + 1)'(phase_q) + (PH_W + 1)'(rates.src_hz);
	assign ge         = sum_w >= out_rate_w;
	assign done       = ge || (n_q == N_W'(rcbf_pkg::MAX_FRAMES - 1));
	assign frames_new = fib_q + FIB_W'(1);
	assign twice_new  = {frames_new, 1'b0};
	assign twice_cur  = {fib_q, 1'b0};
	assign closes     = (frames_new == FIB_W'(FRAMES_PER_BUFFER)) || (done && last_q);
	assign next_buf   = (buf_q == BUF_W'(BUFFER_COUNT - 1)) ? '0 : buf_q + BUF_W'(1);

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		skip_d   = skip_q;
		extra_d  = extra_q;
		buf_d    = buf_q;
		fib_d    = fib_q;
		n_d      = n_q;
		sample_d = sample_q;
		last_d   = last_q;
		pop      = 1'b0;
		load_out = 1'b0;
		res      = '0;
		res.buffer_number = rcbf_pkg::BUFNUM_W'(buf_q);

		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					if (skip_q != '0) begin
						if (head.last) begin
							// skipped last byte: bare end marker, close a nonempty buffer
							if (slot_free) begin
								pop                = 1'b1;
								load_out           = 1'b1;
								res.buffer_end     = fib_q != '0;
								res.buffer_samples = rcbf_pkg::SAMPLES_W'(twice_cur);
								res.last_of_item   = 1'b1;
								phase_d            = '0;
								skip_d             = '0;
								buf_d              = '0;
								fib_d              = '0;
							end
						end else begin
							pop    = 1'b1;
							skip_d = skip_q - rcbf_pkg::SKIP_W'(1);
						end
					end else begin
						pop      = 1'b1;
						sample_d = head.sample;
						last_d   = head.last;
						n_d      = '0;
						state_d  = ST_FRAME;
					end
				end
			end
			ST_FRAME: begin
				if (slot_free) begin
					load_out           = 1'b1;
					res.left_sample    = $signed(sample_q);
					res.right_sample   = $signed(sample_q);
					res.frame_valid    = 1'b1;
					res.frame_slot     = rcbf_pkg::SLOT_W'(fib_q);
					res.buffer_end     = closes;
					res.buffer_samples = closes ? rcbf_pkg::SAMPLES_W'(twice_new) : '0;
					res.last_of_item   = done;
					phase_d = ge ? PH_W'(sum_w - out_rate_w) : PH_W'(sum_w);
					extra_d = '0;
					fib_d   = closes ? '0 : frames_new;
					buf_d   = closes ? next_buf : buf_q;
					if (done) begin
						if (last_q) begin
							phase_d = '0;
							skip_d  = '0;
							buf_d   = '0;
							fib_d   = '0;
							state_d = ST_IDLE;
						end else if (ge) begin
							state_d = ST_SUB;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						n_d = n_q + N_W'(1);
					end
				end
			end
			ST_SUB: begin
				// each further subtraction skips one following byte
				if ((PH_W + 1)'(phase_q) >= out_rate_w) begin
					phase_d = PH_W'((PH_W + 1)'(phase_q) - out_rate_w);
					extra_d = (extra_q == rcbf_pkg::SKIP_MAX) ? extra_q
						: extra_q + rcbf_pkg::SKIP_W'(1);
				end else begin
					skip_d  = extra_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			skip_q      <= '0;
			extra_q     <= '0;
			buf_q       <= '0;
			fib_q       <= '0;
			n_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			skip_q  <= skip_d;
			extra_q <= extra_d;
			buf_q   <= buf_d;
			fib_q   <= fib_d;
			n_q     <= n_d;
			last_q  <= last_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sample_q <= sample_d;
		if (load_out) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

`ifndef NO_ASSERTIONS
	a_fib_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		fib_q < FIB_W'(FRAMES_PER_BUFFER))
		else $error("frame count reached a full buffer without advancing");

	a_no_skip_in_sub: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUB |-> skip_q == '0)
		else $error("skip count pending while phase is still being reduced");

	a_idle_emit_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && state_q == ST_IDLE) |-> (skip_q != '0 && head.last && pop))
		else $error("idle result that is not an end marker of a skipped last byte");

	a_stream_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAME && slot_free && done && last_q)
		|=> (fib_q == '0 && buf_q == '0 && phase_q == '0 && state_q == ST_IDLE))
		else $error("stream end did not restart at buffer zero");
`endif

endmodule

### design/pcm_rate_converter_buffer_filler.sv
// ----------------------------------------------------------------------------
// pcm_rate_converter_buffer_filler
// Zero-order-hold rate converter that packs stereo frames into ring buffers.
// ----------------------------------------------------------------------------
// A source byte leaves the two-entry input queue, then emits 1 to 64 frames,
// one per cycle while the output is taken, then, after its last frame, the
// phase accumulator does its extra subtractions one at a time, about the
// ratio of source to output rate, before the byte is finished. A byte that
// is skipped emits no frame. New bytes are queued while the engine works
// and while a result waits in the output register.
module pcm_rate_converter_buffer_filler #(
	parameter int BUFFER_COUNT      = 16,
	parameter int FRAMES_PER_BUFFER = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [17:0] wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] source_byte
	input  logic        s_tlast,   // source_last
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] left_sample, [31:16] right_sample, [35:32] buffer_number,
	// [45:36] frame_slot, [46] buffer_end, [58:47] buffer_samples, [63:59] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser,   // frame_valid
	output logic        m_tlast    // last_of_item
);

	rcbf_pkg::rates_t  rates_q;
	rcbf_pkg::q_item_t head;
	rcbf_pkg::result_t out_word;
	logic              head_valid;
	logic              pop;
	logic [rcbf_pkg::OUT_RATE_W-1:0] out_wr;

	assign out_wr = wr_data[rcbf_pkg::OUT_RATE_W-1:0];

	// clamp each written value to its register's range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rates_q.src_hz <= rcbf_pkg::SRC_RATE_RESET;
			rates_q.out_hz <= rcbf_pkg::OUT_RATE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				rcbf_pkg::REG_SOURCE_RATE: begin
					if (wr_data < rcbf_pkg::SRC_RATE_MIN) begin
						rates_q.src_hz <= rcbf_pkg::SRC_RATE_MIN;
					end else if (wr_data > rcbf_pkg::SRC_RATE_MAX) begin
						rates_q.src_hz <= rcbf_pkg::SRC_RATE_MAX;
					end else begin
						rates_q.src_hz <= wr_data;
					end
				end
				rcbf_pkg::REG_OUTPUT_RATE: begin
					if (out_wr < rcbf_pkg::OUT_RATE_MIN) begin
						rates_q.out_hz <= rcbf_pkg::OUT_RATE_MIN;
					end else if (out_wr > rcbf_pkg::OUT_RATE_MAX) begin
						rates_q.out_hz <= rcbf_pkg::OUT_RATE_MAX;
					end else begin
						rates_q.out_hz <= out_wr;
					end
				end
				default: begin
					rates_q <= rates_q;
				end
			endcase
		end
	end

	rcbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	rcbf_engine #(
		.BUFFER_COUNT      (BUFFER_COUNT),
		.FRAMES_PER_BUFFER (FRAMES_PER_BUFFER)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.rates      (rates_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_word   (out_word)
	);

	assign m_tdata = {5'b0, out_word.buffer_samples, out_word.buffer_end, out_word.frame_slot,
		out_word.buffer_number, out_word.right_sample, out_word.left_sample};
	assign m_tuser = out_word.frame_valid;
	assign m_tlast = out_word.last_of_item;

endmodule

### dv/tb_pcm_rate_converter_buffer_filler.sv
// ----------------------------------------------------------------------------
// tb_pcm_rate_converter_buffer_filler
// Streams source bytes into the rate converter under random rates and
// backpressure. A cycle-free predictor expands each accepted byte into
// the stereo frames and buffer markers it should produce, and every output
// word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pcm_rate_converter_buffer_filler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFERS       = 16;
	localparam int BUFFER_FRAMES = 1024;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_REPORTS   = 40;

	typedef struct {
		logic [7:0] pcm;
		logic       last;
	} source_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        wr_en    = 1'b0;
	logic        wr_index = rcbf_pkg::REG_SOURCE_RATE;
	logic [17:0] wr_data  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// converter state as the predictor sees it
	logic [rcbf_pkg::SRC_RATE_W-1:0] src_rate  = rcbf_pkg::SRC_RATE_RESET;
	logic [rcbf_pkg::OUT_RATE_W-1:0] out_rate  = rcbf_pkg::OUT_RATE_RESET;
	logic [rcbf_pkg::SRC_RATE_W-1:0] phase_acc = '0;
	logic [rcbf_pkg::SKIP_W-1:0]     skip_left = '0;
	logic [rcbf_pkg::BUFNUM_W-1:0]   buf_idx   = '0;
	logic [10:0]                     buf_fill  = '0;

	rcbf_pkg::result_t frames_due[$];
	source_word_t      words_pending[$];
	int                mismatches = 0;
	int                cycles     = 0;
	int                tx_wait    = 0;
	int                rx_wait    = 0;
	bit                idling     = 1'b1;
	bit                hold_out   = 1'b0;

	pcm_rate_converter_buffer_filler #(
		.BUFFER_COUNT      (BUFFERS),
		.FRAMES_PER_BUFFER (BUFFER_FRAMES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	function automatic void close_stream();
		phase_acc = '0;
		skip_left = '0;
		buf_idx   = '0;
		buf_fill  = '0;
	endfunction

	function automatic void expand_source_byte(input logic [7:0] pcm, input logic last);
		rcbf_pkg::result_t             r;
		logic [rcbf_pkg::SAMPLE_W-1:0] level;
		logic [5:0]                    subs;
		int                            n;
		bit                            done;
		bit                            closes;
		if (skip_left != 0) begin
			skip_left--;
			// a skipped last byte still ends the stream with a bare marker
			if (last) begin
				r                = '0;
				r.buffer_number  = buf_idx;
				r.buffer_end     = (buf_fill != 0);
				r.buffer_samples = r.buffer_end ? {buf_fill, 1'b0} : '0;
				r.last_of_item   = 1'b1;
				frames_due.push_back(r);
				close_stream();
			end
			return;
		end
		level = {pcm ^ rcbf_pkg::SILENCE, 8'h00};
		n     = 0;
		done  = 1'b0;
		while (!done) begin
			r               = '0;
			r.left_sample   = level;
			r.right_sample  = level;
			r.frame_valid   = 1'b1;
			r.buffer_number = buf_idx;
			r.frame_slot    = buf_fill[rcbf_pkg::SLOT_W-1:0];
			buf_fill++;
			phase_acc += src_rate;
			subs = '0;
			// a last byte stops after its first subtraction
			while (phase_acc >= out_rate && !(last && subs != 0)) begin
				phase_acc -= out_rate;
				subs++;
			end
			done             = (subs != 0) || (n == rcbf_pkg::MAX_FRAMES - 1);
			closes           = (buf_fill >= BUFFER_FRAMES) || (done && last);
			r.buffer_end     = closes;
			r.buffer_samples = closes ? {buf_fill, 1'b0} : '0;
			r.last_of_item   = done;
			frames_due.push_back(r);
			if (closes) begin
				buf_idx  = (buf_idx == BUFFERS - 1) ? '0 : buf_idx + 1'b1;
				buf_fill = '0;
			end
			if (done && !last && subs > 1)
				skip_left = (subs - 6'd1 > rcbf_pkg::SKIP_MAX) ? rcbf_pkg::SKIP_MAX
					: rcbf_pkg::SKIP_W'(subs - 6'd1);
			n++;
		end
		if (last)
			close_stream();
	endfunction

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic check_frame();
		rcbf_pkg::result_t want;
		if (frames_due.size() == 0) begin
			report_mismatch("output word with nothing expected");
			return;
		end
		want = frames_due.pop_front();
		check_field("left_sample", m_tdata[15:0], want.left_sample);
		check_field("right_sample", m_tdata[31:16], want.right_sample);
		check_field("buffer_number", 16'(m_tdata[35:32]), 16'(want.buffer_number));
		check_field("frame_slot", 16'(m_tdata[45:36]), 16'(want.frame_slot));
		check_field("buffer_end", 16'(m_tdata[46]), 16'(want.buffer_end));
		check_field("buffer_samples", 16'(m_tdata[58:47]), 16'(want.buffer_samples));
		check_field("frame_valid", 16'(m_tuser), 16'(want.frame_valid));
		check_field("last_of_item", 16'(m_tlast), 16'(want.last_of_item));
	endtask

	// source side: predict on acceptance, then launch the next word after its gap
	always @(posedge clk or negedge arst_n) begin
		source_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_wait = 0;
		end else begin
			if (s_tvalid && s_tready)
				expand_source_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (tx_wait != 0) begin
					tx_wait--;
					s_tvalid <= 1'b0;
				end else if (words_pending.size() != 0) begin
					w = words_pending.pop_front();
					s_tdata  <= w.pcm;
					s_tlast  <= w.last;
					s_tvalid <= 1'b1;
					tx_wait = idling ? $urandom_range(0, 8) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: check each word, then hold ready low for a drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_frame();
				rx_wait = idling ? $urandom_range(0, 8) : 0;
			end
			if (hold_out) begin
				m_tready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_word(input logic [7:0] pcm, input logic last);
		source_word_t w;
		w.pcm  = pcm;
		w.last = last;
		words_pending.push_back(w);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_pending.size() != 0 || s_tvalid || frames_due.size() != 0);
		// let the engine finish trailing phase subtractions and skipped words
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [17:0] val);
		logic [rcbf_pkg::OUT_RATE_W-1:0] o;
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == rcbf_pkg::REG_SOURCE_RATE) begin
			if (val < rcbf_pkg::SRC_RATE_MIN)
				src_rate = rcbf_pkg::SRC_RATE_MIN;
			else if (val > rcbf_pkg::SRC_RATE_MAX)
				src_rate = rcbf_pkg::SRC_RATE_MAX;
			else
				src_rate = val;
		end else begin
			o = val[rcbf_pkg::OUT_RATE_W-1:0];
			if (o < rcbf_pkg::OUT_RATE_MIN)
				out_rate = rcbf_pkg::OUT_RATE_MIN;
			else if (o > rcbf_pkg::OUT_RATE_MAX)
				out_rate = rcbf_pkg::OUT_RATE_MAX;
			else
				out_rate = o;
		end
		@(negedge clk);
	endtask

	initial begin
		logic [17:0] src_val;
		logic [17:0] out_val;
		int          count;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sample extremes at the reset rates, one frame per word
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(8'h7F, 1'b1);
		wait_drained();

		// 64 frames per word fill buffer 0 up to 960 frames
		write_reg(rcbf_pkg::REG_SOURCE_RATE, 18'(rcbf_pkg::SRC_RATE_MIN));
		write_reg(rcbf_pkg::REG_OUTPUT_RATE, 18'(rcbf_pkg::OUT_RATE_MAX));
		repeat (15) push_word(8'($urandom), 1'b0);
		wait_drained();
		// 63 more frames leave one slot free
		write_reg(rcbf_pkg::REG_OUTPUT_RATE, 18'd47250);
		push_word(8'($urandom), 1'b0);
		wait_drained();
		// the closing frame sets three skips, so the stream ends in an empty buffer
		write_reg(rcbf_pkg::REG_SOURCE_RATE, 18'(rcbf_pkg::SRC_RATE_MAX));
		write_reg(rcbf_pkg::REG_OUTPUT_RATE, 18'(rcbf_pkg::OUT_RATE_MAX));
		push_word(8'($urandom), 1'b0);
		push_word(8'($urandom), 1'b0);
		push_word(8'($urandom), 1'b0);
		push_word(8'($urandom), 1'b1);
		wait_drained();

		// fill several buffers in a row, with a long output stall early on
		write_reg(rcbf_pkg::REG_SOURCE_RATE, 18'(rcbf_pkg::SRC_RATE_MIN));
		write_reg(rcbf_pkg::REG_OUTPUT_RATE, 18'(rcbf_pkg::OUT_RATE_MAX));
		repeat (99) push_word(8'($urandom), 1'b0);
		push_word(8'($urandom), 1'b1);
		hold_out = 1'b1;
		repeat (400) @(negedge clk);
		hold_out = 1'b0;
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					src_val = 18'h3FFFF;
					out_val = 18'd0;
				end
				1: begin
					src_val = 18'd0;
					out_val = 18'd8000;
				end
				2: begin
					src_val = 18'(rcbf_pkg::SRC_RATE_MAX);
					out_val = 18'(rcbf_pkg::OUT_RATE_MAX);
				end
				3: begin
					src_val = 18'd750;
					out_val = 18'h1FFFF;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						src_val = 18'($urandom);
						out_val = 18'($urandom);
					end else begin
						src_val = 18'($urandom_range(750, 192000));
						out_val = 18'($urandom_range(8000, 48000));
					end
				end
			endcase
			write_reg(rcbf_pkg::REG_SOURCE_RATE, src_val);
			write_reg(rcbf_pkg::REG_OUTPUT_RATE, out_val);
			idling = (p != 2) && (p != 5);
			count  = $urandom_range(10, 18);
			for (int i = 0; i < count; i++) begin
				// odd phases may leave the stream open across the rate change
				if (i == count - 1)
					push_word(8'($urandom), (p % 2 == 0) || ($urandom_range(0, 1) == 0));
				else
					push_word(8'($urandom), $urandom_range(0, 5) == 0);
			end
			wait_drained();
		end

		if (mismatches == 0 && frames_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
design/rcbf_pkg.sv
design/rcbf_front.sv
design/rcbf_engine.sv
design/pcm_rate_converter_buffer_filler.sv
dv/tb_pcm_rate_converter_buffer_filler.sv
